[hw/rtl/c3z_pkg.sv]
// Shared types and constants of the 3x3 zero-padded convolution block.
package c3z_pkg;

    localparam int WIDTH_W    = 12;   // image_width register
    localparam int HEIGHT_W   = 13;   // image_height register
    localparam int KROW_W     = 24;   // one kernel row, three signed bytes
    localparam int ROW_W      = 13;   // row counter, rows H and H+1 are drain
    localparam int PIX_W      = 8;
    localparam int PROD_W     = 17;   // unsigned pixel times signed coefficient
    localparam int ROWSUM_W   = 19;
    localparam int SUM_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MAX_HEIGHT = 4096;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd2048;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd512;
    localparam logic [KROW_W-1:0]   KROW_RESET   = 24'h010101;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH       = 3'd0,
        REG_IMAGE_HEIGHT      = 3'd1,
        REG_KERNEL_ROW_TOP    = 3'd2,
        REG_KERNEL_ROW_MIDDLE = 3'd3,
        REG_KERNEL_ROW_BOTTOM = 3'd4
    } cfg_reg_t;

    // Per-item control: whether a result is due and which taps fall off the frame.
    typedef struct packed {
        logic emit;
        logic last;
        logic top_m;
        logic bot_m;
        logic left_m;
        logic right_m;
    } tap_ctl_t;

    // One new window column plus its control, front to back.
    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] lower;
        logic [PIX_W-1:0] pixel;
        tap_ctl_t         ctl;
    } column_t;

endpackage

[hw/rtl/c3z_if.sv]
// Channel interfaces of the 3x3 convolution block: pixels, results, configuration.
interface c3z_pixel_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [c3z_pkg::PIX_W-1:0]    pixel;
    modport source (output valid, output mode, output pixel, input ready);
    modport sink   (input valid, input mode, input pixel, output ready);
endinterface

interface c3z_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [c3z_pkg::SUM_W-1:0] filtered;
    logic                             last;
    modport source (output valid, output filtered, output last, input ready);
    modport sink   (input valid, input filtered, input last, output ready);
endinterface

interface c3z_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [c3z_pkg::CFG_IDX_W-1:0]    index;
    logic [c3z_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/c3z_front.sv]
// Front end: raster counters, tap classification and the two line stores.
module c3z_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_mode,
    input  logic [c3z_pkg::PIX_W-1:0]         in_pixel,
    input  logic [c3z_pkg::WIDTH_W-1:0]       image_width,
    input  logic [c3z_pkg::HEIGHT_W-1:0]      image_height,
    input  logic [c3z_pkg::FIFO_CNT_W-1:0]    fifo_count,
    output logic                              push_valid,
    output c3z_pkg::column_t                  push_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = ($clog2(MAX_WIDTH + 1) > c3z_pkg::WIDTH_W) ?
                        $clog2(MAX_WIDTH + 1) : c3z_pkg::WIDTH_W;
    localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);
    localparam int HW = c3z_pkg::HEIGHT_W;
    localparam int RW = c3z_pkg::ROW_W;

    logic [c3z_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [c3z_pkg::PIX_W-1:0] lower_mem [MAX_WIDTH];

    logic [CW-1:0] col_reg, col_next, col_inc;
    logic [RW-1:0] row_reg, row_next;
    logic          f2_valid_reg;

    logic [AW-1:0]             f2_addr_reg;
    logic [c3z_pkg::PIX_W-1:0] f2_pixel_reg;
    c3z_pkg::tap_ctl_t         f2_ctl_reg;
    logic                      f2_fwd_reg;
    logic [c3z_pkg::PIX_W-1:0] upper_rd_reg;
    logic [c3z_pkg::PIX_W-1:0] lower_rd_reg;
    logic [c3z_pkg::PIX_W-1:0] lo_hold_reg;

    logic [CW-1:0]             w_raw, w_eff;
    logic [HW-1:0]             h_eff;
    logic [HW:0]               h_p1;
    logic [HW:0]               r_ext;
    logic                      c0;
    logic                      accept;
    logic [AW-1:0]             addr;
    logic [c3z_pkg::PIX_W-1:0] pix;
    c3z_pkg::tap_ctl_t         ctl;

    // Out-of-range geometry is clamped.
    assign w_raw = CW'(image_width);
    assign w_eff = (w_raw == '0) ? CW'(1) : ((w_raw > MAXW) ? MAXW : w_raw);
    assign h_eff = (image_height == '0) ? HW'(1) :
                   ((image_height > HW'(c3z_pkg::MAX_HEIGHT)) ?
                    HW'(c3z_pkg::MAX_HEIGHT) : image_height);
    assign h_p1  = {1'b0, h_eff} + (HW + 1)'(1);
    assign r_ext = {1'b0, row_reg};

    // Masks are for the window after the shift; at a row start the result
    // belongs to the last column of the row before, centred on window column 1.
    assign c0          = (col_reg == '0);
    assign ctl.emit    = (row_reg >= RW'(2)) || ((row_reg == RW'(1)) && !c0);
    assign ctl.last    = (r_ext >= h_p1);
    assign ctl.top_m   = c0 ? (row_reg == RW'(2)) : (row_reg == RW'(1));
    assign ctl.bot_m   = c0 ? (r_ext >= h_p1) : (r_ext >= {1'b0, h_eff});
    assign ctl.left_m  = c0 ? (w_eff == CW'(1)) : (col_reg == CW'(1));
    assign ctl.right_m = c0 ? 1'b1 : (col_reg >= w_eff);

    assign in_ready = (fifo_count + c3z_pkg::FIFO_CNT_W'(f2_valid_reg)) <
                      c3z_pkg::FIFO_CNT_W'(c3z_pkg::FIFO_DEPTH);
    assign accept   = in_valid && in_ready;
    assign addr     = col_reg[AW-1:0];
    assign pix      = in_mode ? '0 : in_pixel;
    assign col_inc  = col_reg + CW'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            priority if (ctl.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            f2_valid_reg <= accept;
        end
    end

    // Lower store is read and written at accept; the upper store takes the
    // old lower value in the cycle after, with a bypass for the same address.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f2_addr_reg    <= addr;
            f2_pixel_reg   <= pix;
            f2_ctl_reg     <= ctl;
            f2_fwd_reg     <= f2_valid_reg && (f2_addr_reg == addr);
            upper_rd_reg   <= upper_mem[addr];
            lower_rd_reg   <= lower_mem[addr];
            lower_mem[addr] <= pix;
        end
        if (f2_valid_reg)
        begin
            upper_mem[f2_addr_reg] <= lower_rd_reg;
            lo_hold_reg            <= lower_rd_reg;
        end
    end

    assign push_valid      = f2_valid_reg;
    assign push_data.upper = f2_fwd_reg ? lo_hold_reg : upper_rd_reg;
    assign push_data.lower = lower_rd_reg;
    assign push_data.pixel = f2_pixel_reg;
    assign push_data.ctl   = f2_ctl_reg;

endmodule

[hw/rtl/c3z_fifo.sv]
// Short column queue between front and back.
module c3z_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push_valid,
    input  c3z_pkg::column_t               push_data,
    output logic [c3z_pkg::FIFO_CNT_W-1:0] count,
    output logic                           pop_valid,
    input  logic                           pop_ready,
    output c3z_pkg::column_t               pop_data
);

    c3z_pkg::column_t                  entry_reg [c3z_pkg::FIFO_DEPTH];
    logic [c3z_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [c3z_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic                              pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
                wr_ptr_reg <= wr_ptr_reg + c3z_pkg::FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + c3z_pkg::FIFO_PTR_W'(1);
            count_reg <= count_reg + c3z_pkg::FIFO_CNT_W'(push_valid)
                                   - c3z_pkg::FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[hw/rtl/c3z_back.sv]
// Back end: 3x3 window, masked products, adder tree and output register.
module c3z_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   col_valid,
    output logic                                   col_ready,
    input  c3z_pkg::column_t                       col_data,
    input  logic [2:0][c3z_pkg::KROW_W-1:0]        kernel,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [c3z_pkg::SUM_W-1:0]       out_filtered,
    output logic                                   out_last
);

    localparam int PW = c3z_pkg::PROD_W;
    localparam int RSW = c3z_pkg::ROWSUM_W;
    localparam int SW = c3z_pkg::SUM_W;

    // win_reg[row][col]: row 0 above, col 2 newest
    logic [2:0][2:0][c3z_pkg::PIX_W-1:0] win_reg;

    logic              b1_valid_reg, b2_valid_reg, b3_valid_reg, out_valid_reg;
    c3z_pkg::tap_ctl_t b1_ctl_reg;
    logic              b2_last_reg, b3_last_reg, out_last_reg;

    logic signed [PW-1:0]  prod_reg [3][3];
    logic signed [PW-1:0]  prod_next [3][3];
    logic signed [RSW-1:0] rsum_reg [3];
    logic signed [RSW-1:0] rsum_next [3];
    logic signed [SW-1:0]  sum_reg;

    logic b1_ready, b2_ready, b3_ready, o_ready, pop;

    assign o_ready   = !out_valid_reg || out_ready;
    assign b3_ready  = !b3_valid_reg || o_ready;
    assign b2_ready  = !b2_valid_reg || b3_ready;
    assign b1_ready  = !b1_valid_reg || b2_ready;
    assign col_ready = b1_ready;
    assign pop       = col_valid && b1_ready;

    always_comb
    begin
        logic                      m;
        logic [c3z_pkg::PIX_W-1:0] tap;
        logic [7:0]                cb;
        logic signed [PW-1:0]      a_s, k_s, p_full;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m = ((i == 0) && b1_ctl_reg.top_m) || ((i == 2) && b1_ctl_reg.bot_m) ||
                    ((j == 0) && b1_ctl_reg.left_m) || ((j == 2) && b1_ctl_reg.right_m);
                tap    = m ? '0 : win_reg[i][j];
                cb     = kernel[i][8*j +: 8];
                a_s    = $signed({{(PW - c3z_pkg::PIX_W){1'b0}}, tap});
                k_s    = $signed({{(PW - 8){cb[7]}}, cb});
                p_full = a_s * k_s;
                prod_next[i][j] = p_full;
            end
            rsum_next[i] = RSW'(prod_reg[i][0]) + RSW'(prod_reg[i][1]) +
                           RSW'(prod_reg[i][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= col_data.upper;
                win_reg[1][2] <= col_data.lower;
                win_reg[2][2] <= col_data.pixel;
            end
            // Items with no result only move the window.
            if (b1_ready)
                b1_valid_reg <= pop && col_data.ctl.emit;
            if (b2_ready)
                b2_valid_reg <= b1_valid_reg;
            if (b3_ready)
                b3_valid_reg <= b2_valid_reg;
            if (o_ready)
                out_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            b1_ctl_reg <= col_data.ctl;
        if (b1_valid_reg && b2_ready)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    prod_reg[i][j] <= prod_next[i][j];
            b2_last_reg <= b1_ctl_reg.last;
        end
        if (b2_valid_reg && b3_ready)
        begin
            for (int i = 0; i < 3; i++)
                rsum_reg[i] <= rsum_next[i];
            b3_last_reg <= b2_last_reg;
        end
        if (b3_valid_reg && o_ready)
        begin
            sum_reg      <= SW'(rsum_reg[0]) + SW'(rsum_reg[1]) + SW'(rsum_reg[2]);
            out_last_reg <= b3_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_filtered = sum_reg;
    assign out_last     = out_last_reg;

endmodule

[hw/rtl/conv2d_3x3_zero_pad.sv]
// Top level of the streaming 3x3 convolution with zero padding.
//
// Usage: pixels arrive on the pixels channel in raster order, one transaction
// per pixel (mode 0), followed by image_width + 1 drain transactions (mode 1)
// that flush the last row. Each output pixel leaves on the results channel as
// the signed sum of its 3x3 neighbourhood times the kernel, neighbours outside
// the frame counting as zero; the final output of the frame has last set.
// The result for pixel k is produced by input transaction k + W + 1; items
// before that produce no result.
// Throughput: one pixel per clock, sustained while results is ready. An input
// reaches the results channel through the line store read, the column queue
// and the three-stage product/adder tree.
// Stall: when results is not ready the back pipeline and then the four-entry
// column queue fill, and pixels.ready drops; nothing is lost.
// Configuration: cfg is always ready; write only between transactions while
// the block is idle. Reset is asynchronous, active low: counters, window and
// valid bits clear; registers return to width 2048, height 512, all-ones kernel.
// Line stores are not cleared; unwritten entries only feed out-of-frame taps.
module conv2d_3x3_zero_pad #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic          clk,
    input  logic          rst_n,
    c3z_pixel_if.sink     pixels,
    c3z_result_if.source  results,
    c3z_cfg_if.sink       cfg
);

    logic [c3z_pkg::WIDTH_W-1:0]         image_width_reg;
    logic [c3z_pkg::HEIGHT_W-1:0]        image_height_reg;
    logic [2:0][c3z_pkg::KROW_W-1:0]     kernel_reg;   // 0 top, 1 middle, 2 bottom

    logic                                push_valid;
    c3z_pkg::column_t                    push_data;
    logic [c3z_pkg::FIFO_CNT_W-1:0]      fifo_count;
    logic                                col_valid;
    logic                                col_ready;
    c3z_pkg::column_t                    col_data;

    // Configuration write port, one register per transaction.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= c3z_pkg::WIDTH_RESET;
            image_height_reg <= c3z_pkg::HEIGHT_RESET;
            kernel_reg[0]    <= c3z_pkg::KROW_RESET;
            kernel_reg[1]    <= c3z_pkg::KROW_RESET;
            kernel_reg[2]    <= c3z_pkg::KROW_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (c3z_pkg::cfg_reg_t'(cfg.index))
                c3z_pkg::REG_IMAGE_WIDTH:
                    image_width_reg <= cfg.data[c3z_pkg::WIDTH_W-1:0];
                c3z_pkg::REG_IMAGE_HEIGHT:
                    image_height_reg <= cfg.data[c3z_pkg::HEIGHT_W-1:0];
                c3z_pkg::REG_KERNEL_ROW_TOP:
                    kernel_reg[0] <= cfg.data[c3z_pkg::KROW_W-1:0];
                c3z_pkg::REG_KERNEL_ROW_MIDDLE:
                    kernel_reg[1] <= cfg.data[c3z_pkg::KROW_W-1:0];
                c3z_pkg::REG_KERNEL_ROW_BOTTOM:
                    kernel_reg[2] <= cfg.data[c3z_pkg::KROW_W-1:0];
                default:
                    ;   // unmapped index, ignored
            endcase
        end
    end

    // Front: counters, tap masks, line stores.
    c3z_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pixels.valid),
        .in_ready     (pixels.ready),
        .in_mode      (pixels.mode),
        .in_pixel     (pixels.pixel),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .fifo_count   (fifo_count),
        .push_valid   (push_valid),
        .push_data    (push_data)
    );

    // Column queue decouples line store timing from output stalls.
    c3z_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .count      (fifo_count),
        .pop_valid  (col_valid),
        .pop_ready  (col_ready),
        .pop_data   (col_data)
    );

    // Back: window, products, sum, output register.
    c3z_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .col_valid    (col_valid),
        .col_ready    (col_ready),
        .col_data     (col_data),
        .kernel       (kernel_reg),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .out_filtered (results.filtered),
        .out_last     (results.last)
    );

endmodule

[hw/rtl/c3z_checker.sv]
// Port-level assertions of the 3x3 convolution block and their bind.
module c3z_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             pix_valid,
    input logic                             pix_ready,
    input logic                             res_valid,
    input logic                             res_ready,
    input logic signed [c3z_pkg::SUM_W-1:0] res_filtered,
    input logic                             res_last,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);

    logic seen_input_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_input_reg <= 1'b0;
        else if (pix_valid && pix_ready)
            seen_input_reg <= 1'b1;
    end

    // Stalled result holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_filtered) && $stable(res_last))
        else $error("result changed while stalled");

    // Nothing shown at reset release.
    a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

    // No result before any pixel transaction.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> seen_input_reg)
        else $error("result without any input");

    // Config port never back-pressures.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind conv2d_3x3_zero_pad c3z_checker u_c3z_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_valid    (pixels.valid),
    .pix_ready    (pixels.ready),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .res_filtered (results.filtered),
    .res_last     (results.last),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready)
);

[tb/conv2d_3x3_zero_pad_test.sv]
// Self-checking testbench of the streaming 3x3 zero-padded convolution block.
module conv2d_3x3_zero_pad_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = 2048;
    localparam int RANDOM_ITEMS  = 800;
    localparam int SETTLE_CYCLES = 16;      // well past the pipeline latency
    localparam int LONG_HOLD     = 400;     // receiver hold-off, far beyond queue depth

    typedef enum int
    {
        STYLE_RANDOM,
        STYLE_FULL,
        STYLE_CHECKER
    } pixel_style_t;

    typedef struct packed
    {
        logic                      mode;
        logic [c3z_pkg::PIX_W-1:0] pixel;
    } pixel_item_t;

    typedef struct packed
    {
        logic signed [c3z_pkg::SUM_W-1:0] filtered;
        logic                             last;
    } conv_result_t;

    logic clk;
    logic rst_n;

    c3z_pixel_if  pixels_ch ();
    c3z_result_if results_ch ();
    c3z_cfg_if    cfg_ch ();

    conv2d_3x3_zero_pad u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the registers, line stores, window
    // and position counters.
    // ------------------------------------------------------------------
    logic [c3z_pkg::WIDTH_W-1:0]  width_reg;
    logic [c3z_pkg::HEIGHT_W-1:0] height_reg;
    logic [c3z_pkg::KROW_W-1:0]   kernel_rows [3];      // 0 top, 1 middle, 2 bottom
    logic [c3z_pkg::PIX_W-1:0]    upper_row_px [MAX_W];
    logic [c3z_pkg::PIX_W-1:0]    lower_row_px [MAX_W];
    logic [c3z_pkg::PIX_W-1:0]    taps [3][3];          // [above/centre/below][left..right]
    int unsigned                  next_col;
    int unsigned                  next_row;

    pixel_item_t  pixel_queue [$];             // pixels waiting to be offered
    conv_result_t pending_outputs [$];         // predicted results, oldest first

    int  error_count     = 0;
    int  frames_sent     = 0;
    int  pixels_accepted = 0;
    int  results_checked = 0;
    int  send_gap        = 0;
    int  recv_gap        = 0;
    int  hold_off_left   = 0;
    bit  calm            = 1'b0;               // no idling in the closing part
    bit  long_stall_req  = 1'b0;

    // Out-of-range widths and heights clamp to the supported span.
    function automatic int eff_width();
        int w;
        w = int'(width_reg);
        if (w == 0)
            w = 1;
        if (w > MAX_W)
            w = MAX_W;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(height_reg);
        if (h == 0)
            h = 1;
        if (h > c3z_pkg::MAX_HEIGHT)
            h = c3z_pkg::MAX_HEIGHT;
        return h;
    endfunction

    function automatic void reset_predictor();
        width_reg  = c3z_pkg::WIDTH_RESET;
        height_reg = c3z_pkg::HEIGHT_RESET;
        for (int i = 0; i < 3; i++)
            kernel_rows[i] = c3z_pkg::KROW_RESET;
        for (int i = 0; i < MAX_W; i++)
        begin
            upper_row_px[i] = '0;
            lower_row_px[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                taps[i][j] = '0;
        next_col = 0;
        next_row = 0;
    endfunction

    // Sum of the window taps around one output pixel; first_col picks which
    // window column acts as the left neighbour. Taps off the frame are dropped.
    function automatic int neighborhood_sum(int first_col, int cr, int cc, int w, int h);
        int total;
        int col;
        int coeff;
        total = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (i == 0 && cr == 0)
                continue;
            if (i == 2 && cr + 1 >= h)
                continue;
            for (int j = 0; j < 3; j++)
            begin
                col = first_col + j;
                if (j == 0 && cc == 0)
                    continue;
                if (j == 2 && cc + 1 >= w)
                    continue;
                if (col > 2)
                    continue;
                coeff = int'($signed(kernel_rows[i][8*j +: 8]));
                total += int'(taps[i][col]) * coeff;
            end
        end
        return total;
    endfunction

    // Advances the predictor by one accepted pixel transaction; returns 1
    // when that transaction releases an output pixel.
    function automatic bit convolve_pixel(input logic mode,
                                          input logic [c3z_pkg::PIX_W-1:0] pix,
                                          output conv_result_t outcome);
        int                        w;
        int                        h;
        int unsigned               r;
        int unsigned               c;
        logic [c3z_pkg::PIX_W-1:0] p;
        logic [c3z_pkg::PIX_W-1:0] up;
        logic [c3z_pkg::PIX_W-1:0] lo;
        bit                        emit;
        bit                        is_last;
        int                        sum;
        w   = eff_width();
        h   = eff_height();
        r   = next_row;
        c   = next_col;
        p   = mode ? '0 : pix;
        up  = '0;
        lo  = '0;
        sum = 0;

        emit    = (r >= 2) || (r == 1 && c >= 1);
        is_last = (r >= h + 1);

        // Row start: the output is the last column two rows up, old window.
        if (emit && c == 0)
            sum = neighborhood_sum(1, r - 2, w - 1, w, h);

        if (c < MAX_W)
        begin
            up = upper_row_px[c];
            lo = lower_row_px[c];
            upper_row_px[c] = lo;
            lower_row_px[c] = p;
        end
        for (int i = 0; i < 3; i++)
        begin
            taps[i][0] = taps[i][1];
            taps[i][1] = taps[i][2];
        end
        taps[0][2] = up;
        taps[1][2] = lo;
        taps[2][2] = p;

        if (emit && c != 0)
            sum = neighborhood_sum(0, r - 1, c - 1, w, h);

        if (is_last)
        begin
            next_row = 0;
            next_col = 0;
        end
        else
        begin
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
            end
            next_col = c;
            next_row = r;
        end

        outcome.filtered = sum[c3z_pkg::SUM_W-1:0];
        outcome.last     = is_last;
        return emit;
    endfunction

    // Transactions from position (r, c) up to and including the frame's last one.
    function automatic int items_left(int unsigned r, int unsigned c);
        int n;
        int w;
        int h;
        w = eff_width();
        h = eff_height();
        n = 1;
        while (r < h + 1)
        begin
            n++;
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
            end
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Pixel driver: offers queued items, inserts random gaps, and feeds
    // every accepted transaction to the predictor.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_pixels
        conv_result_t outcome;
        pixel_item_t  item;
        if (rst_n)
        begin
            if (pixels_ch.valid && pixels_ch.ready)
            begin
                if (convolve_pixel(pixels_ch.mode, pixels_ch.pixel, outcome))
                    pending_outputs.push_back(outcome);
                pixels_accepted++;
            end
            // Payload may only change once the current transaction is gone.
            if (!pixels_ch.valid || pixels_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pixels_ch.valid <= 1'b0;
                end
                else if (pixel_queue.size() == 0)
                    pixels_ch.valid <= 1'b0;
                else if (!calm && $urandom_range(0, 11) == 0)
                begin
                    send_gap = $urandom_range(0, 16);   // this cycle is the first idle one
                    pixels_ch.valid <= 1'b0;
                end
                else
                begin
                    item = pixel_queue.pop_front();
                    pixels_ch.valid <= 1'b1;
                    pixels_ch.mode  <= item.mode;
                    pixels_ch.pixel <= item.pixel;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts, plus one long hold-off that
    // backs the block up until it stops taking pixels.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                hold_off_left  = LONG_HOLD;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                results_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                results_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                recv_gap = $urandom_range(0, 16);
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result transaction against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        conv_result_t due;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual filtered %0d last %0b",
                         $time, results_ch.filtered, results_ch.last);
                error_count++;
            end
            else
            begin
                due = pending_outputs.pop_front();
                if (results_ch.filtered !== due.filtered)
                begin
                    $display("%0t ns: filtered mismatch, expected %0d, actual %0d",
                             $time, due.filtered, results_ch.filtered);
                    error_count++;
                end
                if (results_ch.last !== due.last)
                begin
                    $display("%0t ns: last mismatch, expected %0b, actual %0b",
                             $time, due.last, results_ch.last);
                    error_count++;
                end
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // One register write; the predictor takes the new value on the same edge.
    task automatic write_register(input c3z_pkg::cfg_reg_t idx,
                                  input logic [c3z_pkg::KROW_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            c3z_pkg::REG_IMAGE_WIDTH:       width_reg      = value[c3z_pkg::WIDTH_W-1:0];
            c3z_pkg::REG_IMAGE_HEIGHT:      height_reg     = value[c3z_pkg::HEIGHT_W-1:0];
            c3z_pkg::REG_KERNEL_ROW_TOP:    kernel_rows[0] = value;
            c3z_pkg::REG_KERNEL_ROW_MIDDLE: kernel_rows[1] = value;
            c3z_pkg::REG_KERNEL_ROW_BOTTOM: kernel_rows[2] = value;
            default: ;
        endcase
    endtask

    // Sender pauses here until every predicted result has come back, then
    // lets the pipeline settle so result-less transactions are done too.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || pixels_ch.valid || pending_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Queues count transactions; the tail W+1 are drain transactions, and
    // with flip_odds set an occasional one takes the other mode.
    task automatic queue_frame(input int count, input pixel_style_t style, input int flip_odds);
        pixel_item_t item;
        int          w;
        w = eff_width();
        for (int i = 0; i < count; i++)
        begin
            item.mode = (i >= count - (w + 1));
            if (flip_odds != 0 && $urandom_range(0, flip_odds - 1) == 0)
                item.mode = ~item.mode;
            case (style)
                STYLE_FULL:    item.pixel = 8'hFF;
                STYLE_CHECKER: item.pixel = (i % 2) ? 8'hFF : 8'h00;
                default:       item.pixel = c3z_pkg::PIX_W'($urandom_range(0, 255));
            endcase
            pixel_queue.push_back(item);
        end
        frames_sent++;
    endtask

    function automatic logic [c3z_pkg::KROW_W-1:0] pick_kernel_row();
        case ($urandom_range(0, 5))
            0:       return 24'h7F7F7F;
            1:       return 24'h808080;
            2:       return 24'h7F807F;
            default: return c3z_pkg::KROW_W'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        int n;
        int head;
        int random_items;
        int frame_no;

        rst_n            = 1'b0;
        pixels_ch.valid  = 1'b0;
        pixels_ch.mode   = 1'b0;
        pixels_ch.pixel  = '0;
        results_ch.ready = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = c3z_pkg::REG_IMAGE_WIDTH;
        cfg_ch.data      = '0;
        reset_predictor();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed: tiny frame on the reset kernel with mode flips in both
        // the pixel and the drain part.
        write_register(c3z_pkg::REG_IMAGE_WIDTH, 2);
        write_register(c3z_pkg::REG_IMAGE_HEIGHT, 2);
        queue_frame(items_left(0, 0), STYLE_CHECKER, 3);

        // Largest positive sum: full-scale pixels on an all +127 kernel.
        wait_until_drained();
        write_register(c3z_pkg::REG_IMAGE_WIDTH, 3);
        write_register(c3z_pkg::REG_IMAGE_HEIGHT, 3);
        write_register(c3z_pkg::REG_KERNEL_ROW_TOP, 24'h7F7F7F);
        write_register(c3z_pkg::REG_KERNEL_ROW_MIDDLE, 24'h7F7F7F);
        write_register(c3z_pkg::REG_KERNEL_ROW_BOTTOM, 24'h7F7F7F);
        queue_frame(items_left(0, 0), STYLE_FULL, 0);

        // Most negative sum: all -128 kernel.
        wait_until_drained();
        write_register(c3z_pkg::REG_KERNEL_ROW_TOP, 24'h808080);
        write_register(c3z_pkg::REG_KERNEL_ROW_MIDDLE, 24'h808080);
        write_register(c3z_pkg::REG_KERNEL_ROW_BOTTOM, 24'h808080);
        queue_frame(items_left(0, 0), STYLE_FULL, 0);

        // Zero width and height behave as one.
        wait_until_drained();
        write_register(c3z_pkg::REG_IMAGE_WIDTH, 0);
        write_register(c3z_pkg::REG_IMAGE_HEIGHT, 0);
        queue_frame(items_left(0, 0), STYLE_RANDOM, 2);

        // Two full rows at width 12, so every line store entry that a
        // mid-frame width change can reach holds written data.
        wait_until_drained();
        write_register(c3z_pkg::REG_IMAGE_WIDTH, 12);
        write_register(c3z_pkg::REG_IMAGE_HEIGHT, 1);
        write_register(c3z_pkg::REG_KERNEL_ROW_TOP, pick_kernel_row());
        write_register(c3z_pkg::REG_KERNEL_ROW_MIDDLE, pick_kernel_row());
        write_register(c3z_pkg::REG_KERNEL_ROW_BOTTOM, pick_kernel_row());
        queue_frame(items_left(0, 0), STYLE_RANDOM, 8);

        // Random small frames. About a third stream back to back with no
        // register change, so frame restarts happen under load.
        random_items = 0;
        frame_no     = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            frame_no++;
            if (frame_no == 1 || frame_no == 6 || $urandom_range(0, 2) != 0)
            begin
                wait_until_drained();
                if (frame_no == 1 || $urandom_range(0, 1))
                    write_register(c3z_pkg::REG_IMAGE_WIDTH,
                                   c3z_pkg::KROW_W'($urandom_range(0, 12)));
                if (frame_no == 1 || $urandom_range(0, 1))
                    write_register(c3z_pkg::REG_IMAGE_HEIGHT,
                                   c3z_pkg::KROW_W'($urandom_range(0, 8)));
                if ($urandom_range(0, 1))
                    write_register(c3z_pkg::REG_KERNEL_ROW_TOP, pick_kernel_row());
                if ($urandom_range(0, 1))
                    write_register(c3z_pkg::REG_KERNEL_ROW_MIDDLE, pick_kernel_row());
                if ($urandom_range(0, 1))
                    write_register(c3z_pkg::REG_KERNEL_ROW_BOTTOM, pick_kernel_row());
                if (frame_no == 6)
                begin
                    write_register(c3z_pkg::REG_IMAGE_WIDTH, 16);
                    write_register(c3z_pkg::REG_IMAGE_HEIGHT, 10);
                end
            end

            n = items_left(0, 0);
            if (frame_no == 6)
            begin
                // Long receiver hold-off while the sender keeps offering.
                queue_frame(n, STYLE_RANDOM, 32);
                @(negedge clk);
                long_stall_req = 1'b1;
                random_items += n;
            end
            else if (n > 1 && $urandom_range(0, 7) == 0)
            begin
                // Registers rewritten mid-frame while idle; counters carry on.
                head = $urandom_range(1, n - 1);
                queue_frame(head, STYLE_RANDOM, 0);
                wait_until_drained();
                write_register(c3z_pkg::REG_KERNEL_ROW_TOP, pick_kernel_row());
                write_register(c3z_pkg::REG_KERNEL_ROW_BOTTOM, pick_kernel_row());
                if ($urandom_range(0, 1))
                    write_register(c3z_pkg::REG_IMAGE_HEIGHT,
                                   c3z_pkg::KROW_W'($urandom_range(0, 8)));
                if ($urandom_range(0, 1))
                    write_register(c3z_pkg::REG_IMAGE_WIDTH,
                                   c3z_pkg::KROW_W'($urandom_range(1, 12)));
                n = items_left(next_row, next_col);
                queue_frame(n, STYLE_RANDOM, 24);
                random_items += head + n;
            end
            else
            begin
                queue_frame(n, ($urandom_range(0, 9) == 0) ? STYLE_CHECKER : STYLE_RANDOM, 24);
                random_items += n;
            end
        end

        // Closing part: full rate on both sides.
        wait_until_drained();
        calm = 1'b1;
        write_register(c3z_pkg::REG_IMAGE_WIDTH, c3z_pkg::KROW_W'($urandom_range(3, 12)));
        write_register(c3z_pkg::REG_IMAGE_HEIGHT, c3z_pkg::KROW_W'($urandom_range(3, 8)));
        for (int k = 0; k < 3; k++)
            queue_frame(items_left(0, 0), STYLE_RANDOM, 24);

        wait_until_drained();
        $display("Run covered %0d frames, %0d pixel transactions, %0d results checked,",
                 frames_sent, pixels_accepted, results_checked);
        $display("widths 1 to 16, heights 1 to 10, zero geometry, extreme kernels, %s",
                 "mode flips, a long output stall and mid-frame rewrites.");
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("Timeout at %0t ns with %0d results outstanding", $time, pending_outputs.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
